// File: rtl/gf2_matrix_vector_multiply_unit_defines.svh
// Assertion macros for the GF(2) matrix-vector multiply unit.
// Both expect clk_i in scope; GF2MV_ASSERT also expects rst_ni.
`ifndef GF2_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define GF2_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// Checked only out of reset.
`define GF2MV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define GF2MV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/gf2mv_pkg.sv
`default_nettype none
package gf2mv_pkg;

  localparam int unsigned DEFAULT_MATRIX_SIZE = 64;
  localparam int unsigned WORD_W              = 64;
  localparam int unsigned IDX_W               = 6;
  // rows folded per lane in the partial stage
  localparam int unsigned GROUP_SIZE          = 8;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_MULTIPLY = 1'b1
  } op_e;

  // per-stage control: incoming valid and register enable
  typedef struct packed {
    logic valid;
    logic adv;
  } stage_ctl_t;

endpackage
`default_nettype wire

// File: rtl/gf2mv_row_store.sv
`default_nettype none
module gf2mv_row_store import gf2mv_pkg::*; #(
  parameter int unsigned MATRIX_SIZE = DEFAULT_MATRIX_SIZE,
  localparam int unsigned ROW_AW = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [ROW_AW-1:0]      wr_addr_i,
  input  logic [MATRIX_SIZE-1:0] wr_data_i,
  output logic [MATRIX_SIZE-1:0] rows_o [MATRIX_SIZE]
);

  logic [MATRIX_SIZE-1:0] rows_q [MATRIX_SIZE];

  // every row feeds the partial XOR lane of its group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MATRIX_SIZE; r++) begin
        rows_q[r] <= '0;
      end
    end else if (wr_en_i) begin
      rows_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rows_o = rows_q;

endmodule
`default_nettype wire

// File: rtl/gf2mv_partial_xor.sv
`default_nettype none
module gf2mv_partial_xor import gf2mv_pkg::*; #(
  parameter int unsigned MATRIX_SIZE = DEFAULT_MATRIX_SIZE,
  localparam int unsigned NUM_GROUPS = (MATRIX_SIZE + GROUP_SIZE - 1) / GROUP_SIZE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stage_ctl_t             ctl_i,
  input  logic [MATRIX_SIZE-1:0] vec_i,
  input  logic [MATRIX_SIZE-1:0] rows_i [MATRIX_SIZE],
  output logic                   valid_o,
  output logic [MATRIX_SIZE-1:0] part_o [NUM_GROUPS]
);

  logic                   valid_q;
  logic [MATRIX_SIZE-1:0] part_d [NUM_GROUPS];
  logic [MATRIX_SIZE-1:0] part_q [NUM_GROUPS];

  // each lane folds up to GROUP_SIZE selected rows
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MATRIX_SIZE) begin
          part_d[g] = part_d[g] ^ (rows_i[g * GROUP_SIZE + k]
                      & {MATRIX_SIZE{vec_i[g * GROUP_SIZE + k]}});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.valid) begin
      part_q <= part_d;
    end
  end

  assign valid_o = valid_q;
  assign part_o  = part_q;

endmodule
`default_nettype wire

// File: rtl/gf2mv_reduce.sv
`default_nettype none
module gf2mv_reduce import gf2mv_pkg::*; #(
  parameter int unsigned MATRIX_SIZE = DEFAULT_MATRIX_SIZE,
  localparam int unsigned NUM_GROUPS = (MATRIX_SIZE + GROUP_SIZE - 1) / GROUP_SIZE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stage_ctl_t             ctl_i,
  input  logic [MATRIX_SIZE-1:0] part_i [NUM_GROUPS],
  output logic                   valid_o,
  output logic [WORD_W-1:0]      product_o
);

  logic                   valid_q;
  logic [MATRIX_SIZE-1:0] acc;
  logic [WORD_W-1:0]      product_d;
  logic [WORD_W-1:0]      product_q;

  always_comb begin
    acc = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      acc = acc ^ part_i[g];
    end
    // columns past the matrix width read as zero
    product_d                  = '0;
    product_d[MATRIX_SIZE-1:0] = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.valid) begin
      product_q <= product_d;
    end
  end

  assign valid_o   = valid_q;
  assign product_o = product_q;

endmodule
`default_nettype wire

// File: rtl/gf2_matrix_vector_multiply_unit.sv
// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   operation_i, row_index_i, data_word_i
// out       out  out_valid_o/out_ready_i product_o
//
// Sustains one word per cycle while the output is not stalled, loads and multiplies mixed in any order.
// A multiply passes through the input register, the
// 8-row partial XOR lanes and the final XOR into the output register.
// A load writes its row as it leaves the input register and yields no word.
// Reset clears all rows to zero at once (flip-flops, no clearing pass).
// Each stage holds a multiply under back-pressure and takes a new word into any bubble.
`default_nettype none
module gf2_matrix_vector_multiply_unit import gf2mv_pkg::*; #(
  parameter int unsigned MATRIX_SIZE = DEFAULT_MATRIX_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [WORD_W-1:0] data_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] product_o
);

  localparam int unsigned ROW_AW = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int unsigned NUM_GROUPS = (MATRIX_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [IDX_W:0] ROW_LIMIT = (IDX_W + 1)'(MATRIX_SIZE);

  // stage 1: input register
  logic                   s1_valid_q;
  op_e                    s1_op_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic [MATRIX_SIZE-1:0] s1_word_q;   // high vector bits dropped here

  logic s1_is_load;
  logic s1_free;
  logic s2_valid;
  logic s2_free;
  logic s3_en;
  logic row_ok;
  logic wr_en;

  stage_ctl_t s2_ctl;
  stage_ctl_t s3_ctl;

  logic [MATRIX_SIZE-1:0] rows [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] part [NUM_GROUPS];

  // ready ripples back from the output register
  assign s3_en      = !out_valid_o || out_ready_i;
  assign s2_free    = !s2_valid || s3_en;
  assign s1_is_load = (s1_op_q == OP_LOAD);
  // a load never waits on later stages, it leaves as it writes
  assign s1_free    = !s1_valid_q || s1_is_load || s2_free;
  assign in_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_op_q   <= op_e'(operation_i);
      s1_idx_q  <= row_index_i;
      s1_word_q <= data_word_i[MATRIX_SIZE-1:0];
    end
  end

  // rows past the matrix are ignored
  assign row_ok = ({1'b0, s1_idx_q} < ROW_LIMIT);
  assign wr_en  = s1_valid_q && s1_is_load && row_ok;

  gf2mv_row_store #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_row_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_idx_q[ROW_AW-1:0]),
    .wr_data_i (s1_word_q),
    .rows_o    (rows)
  );

  // stage 2: partial XOR lanes, multiplies only
  assign s2_ctl.valid = s1_valid_q && !s1_is_load;
  assign s2_ctl.adv   = s2_free;

  gf2mv_partial_xor #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_partial_xor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s2_ctl),
    .vec_i   (s1_word_q),
    .rows_i  (rows),
    .valid_o (s2_valid),
    .part_o  (part)
  );

  // stage 3: final fold into the output register
  assign s3_ctl.valid = s2_valid;
  assign s3_ctl.adv   = s3_en;

  gf2mv_reduce #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (s3_ctl),
    .part_i    (part),
    .valid_o   (out_valid_o),
    .product_o (product_o)
  );

endmodule
`default_nettype wire

// File: rtl/gf2mv_checker.sv
`default_nettype none
`include "gf2_matrix_vector_multiply_unit_defines.svh"
module gf2mv_checker import gf2mv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              operation_i,
  input logic [IDX_W-1:0]  row_index_i,
  input logic [WORD_W-1:0] data_word_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [WORD_W-1:0] product_o
);

  // waiting in word holds
  `GF2MV_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable({operation_i, row_index_i, data_word_i}), "in word changed")
  // stalled word holds
  `GF2MV_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out word dropped")
  `GF2MV_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(product_o), "out word changed")
  // an empty output register means the whole pipe can move
  `GF2MV_ASSERT(a_ready_when_drained, !out_valid_o |-> in_ready_o, "in stalled with empty out")
  `GF2MV_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "out valid in reset")

endmodule

bind gf2_matrix_vector_multiply_unit gf2mv_checker u_gf2mv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .operation_i (operation_i),
  .row_index_i (row_index_i),
  .data_word_i (data_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .product_o   (product_o)
);
`default_nettype wire
